[src/record_queue_search_sort_defines.svh]
// Assertion macros shared by the record queue RTL.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef RECORD_QUEUE_SEARCH_SORT_DEFINES_SVH
`define RECORD_QUEUE_SEARCH_SORT_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define RQSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define RQSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rqss_pkg.sv]
// Shared types and constants of the record queue.
// No dependencies.
package rqss_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [15:0] FIRST_ID = 16'd1001;

  localparam logic [2:0] FN_PLACE  = 3'd0;
  localparam logic [2:0] FN_SERVE  = 3'd1;
  localparam logic [2:0] FN_LIST   = 3'd2;
  localparam logic [2:0] FN_SEARCH = 3'd3;
  localparam logic [2:0] FN_SORT   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] customer;
    logic [15:0] item;
    logic [19:0] price;
  } rec_t;

  // Ring control from the sequencer to the chain of cells.
  typedef struct packed {
    logic shift;
    logic wr;
    rec_t wr_rec;
  } ring_ctl_t;

endpackage

[src/record_queue_search_sort.sv]
// Record queue with search and exchange sort, built as a rotating ring of cells.
// Depends on rqss_pkg, rqss_cell and rqss_ctrl.
//
//  channel | direction | tdata                                   | tuser      | tlast
//  s       | in        | customer, item, price_cents, search_key | func       | -
//  m       | out       | id, customer, item, price               | status     | last
//
// The record ring turns by one cell a cycle unless stalled, and only cell 0 is looked
// at, so place and serve wait for their slot to come round; display waits for the first
// record and then gives the records as they come round; search waits for the head and
// then compares records in turn; sort waits for the head and, for each pending slot,
// stores there the minimum of the slots left. One item is worked at a time.
// Reset clears the pointers and sets the ID counter to 1001; cell contents are not cleared.
// A stalled result stops the ring until it is taken.
module record_queue_search_sort (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // customer_tag[15:0], item_tag[31:16], price_cents[51:32], search_key[67:52]
  input  logic [71:0] s_tdata,
  // func[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // record_id[15:0], record_customer[31:16], record_item[47:32], record_price[67:48]
  output logic [71:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam int D = rqss_pkg::DEPTH;

  rqss_pkg::rec_t      cells [D];
  rqss_pkg::rec_t      nbrs  [D];
  rqss_pkg::ring_ctl_t ctl;
  rqss_pkg::rec_t      in_rec;
  rqss_pkg::rec_t      out_rec;

  // Unpack the input beat.
  assign in_rec = '{id: 16'd0, customer: s_tdata[15:0], item: s_tdata[31:16],
                    price: s_tdata[51:32]};

  // Chain of cells; the last cell takes cell 0 back, or a written record.
  genvar k;
  generate
    for (k = 0; k < D; k++) begin : g_cell
      if (k == D - 1) begin : g_tail
        assign nbrs[k] = ctl.wr ? ctl.wr_rec : cells[0];
      end else begin : g_body
        assign nbrs[k] = cells[k + 1];
      end
      rqss_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .nbr   (nbrs[k]),
        .rec   (cells[k])
      );
    end
  endgenerate

  rqss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .func       (s_tuser),
    .in_rec     (in_rec),
    .key_in     (s_tdata[67:52]),
    .cell0      (cells[0]),
    .ctl        (ctl),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_rec    (out_rec),
    .out_status (m_tuser),
    .out_last   (m_tlast)
  );

  // Pack the output beat.
  assign m_tdata = {4'd0, out_rec.price, out_rec.item, out_rec.customer, out_rec.id};

endmodule

[src/rqss_cell.sv]
// One storage cell of the record ring.
// Depends on rqss_pkg.
module rqss_cell (
  input  logic          clk,
  input  logic          shift,
  input  rqss_pkg::rec_t nbr,
  output rqss_pkg::rec_t rec
);

  // Take the neighbour's record whenever the ring turns.
  always_ff @(posedge clk) begin
    if (shift) begin
      rec <= nbr;
    end
  end

endmodule

[src/rqss_ctrl.sv]
// Sequencer of the record queue: pointers, operations and output register.
// Depends on rqss_pkg and the assertion macro header.
`include "record_queue_search_sort_defines.svh"
module rqss_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2:0]           func,
  input  rqss_pkg::rec_t       in_rec,
  input  logic [15:0]          key_in,
  input  rqss_pkg::rec_t       cell0,
  output rqss_pkg::ring_ctl_t  ctl,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output rqss_pkg::rec_t       out_rec,
  output logic [1:0]           out_status,
  output logic                 out_last
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PLACE  = 3'd1;
  localparam logic [2:0] S_SERVE  = 3'd2;
  localparam logic [2:0] S_LIST   = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_SORTLD = 3'd5;
  localparam logic [2:0] S_SORTSC = 3'd6;
  localparam logic [2:0] S_SORTST = 3'd7;
  localparam int IW = rqss_pkg::IDX_W;

  logic [2:0]      state;
  logic            report;
  logic [1:0]      rep_status;
  logic            started;
  logic [IW:0]     head;
  logic [IW-1:0]   tail;
  logic [15:0]     next_id;
  logic [IW-1:0]   ptr;
  logic [IW:0]     idx;
  logic [IW-1:0]   ii;
  logic [15:0]     key;
  rqss_pkg::rec_t  hold;
  logic            out_free;
  logic            out_load;
  logic            hit;
  logic            empty;
  logic            full;
  logic            accept;

  assign out_free = !m_tvalid || m_tready;
  assign hit      = ({1'b0, ptr} == idx);
  assign empty    = !started || (head > {1'b0, tail});
  assign full     = started && (tail == IW'(rqss_pkg::DEPTH - 1));
  assign s_tready = (state == S_IDLE) && !report;
  assign accept   = s_tvalid && s_tready;

  // A new result beat is loaded into the output register this cycle.
  assign out_load = report ? out_free :
                    (hit && out_free &&
                     ((state inside {S_PLACE, S_SERVE, S_LIST}) ||
                      ((state == S_SEARCH) && (cell0.id == key))));

  // Ring turn and write decisions.
  always_comb begin
    ctl.shift  = 1'b0;
    ctl.wr     = 1'b0;
    ctl.wr_rec = hold;
    case (state)
      S_PLACE: begin
        ctl.shift = !hit || out_free;
        ctl.wr    = hit && out_free;
      end
      S_SERVE: begin
        ctl.shift = !hit;
      end
      S_LIST: begin
        ctl.shift = !hit || (out_free && (idx != {1'b0, tail}));
      end
      S_SEARCH: begin
        ctl.shift = !hit || ((cell0.id != key) && (idx != {1'b0, tail}));
      end
      S_SORTLD: begin
        ctl.shift = 1'b1;
      end
      S_SORTSC: begin
        ctl.shift = (idx <= {1'b0, tail});
        ctl.wr    = hit && (idx <= {1'b0, tail}) && (hold.price > cell0.price);
      end
      S_SORTST: begin
        ctl.shift = 1'b1;
        ctl.wr    = hit;
      end
      default: begin
        ctl.shift = 1'b0;
      end
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      report   <= 1'b0;
      started  <= 1'b0;
      head     <= '0;
      tail     <= '0;
      next_id  <= rqss_pkg::FIRST_ID;
      ptr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      if (ctl.shift) begin
        ptr <= ptr + 1'b1;
      end
      if (report) begin
        if (out_free) begin
          out_rec    <= '0;
          out_status <= rep_status;
          out_last   <= 1'b1;
          report     <= 1'b0;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (accept) begin
              case (func)
                rqss_pkg::FN_PLACE: begin
                  if (full) begin
                    report     <= 1'b1;
                    rep_status <= rqss_pkg::ST_FULL;
                  end else begin
                    hold    <= '{id: next_id, customer: in_rec.customer,
                                 item: in_rec.item, price: in_rec.price};
                    next_id <= next_id + 16'd1;
                    started <= 1'b1;
                    if (started) begin
                      tail <= tail + 1'b1;
                      idx  <= {1'b0, tail} + 1'b1;
                    end else begin
                      tail <= '0;
                      head <= '0;
                      idx  <= '0;
                    end
                    state <= S_PLACE;
                  end
                end
                rqss_pkg::FN_SERVE, rqss_pkg::FN_LIST, rqss_pkg::FN_SORT: begin
                  if (empty) begin
                    report     <= 1'b1;
                    rep_status <= rqss_pkg::ST_EMPTY;
                  end else begin
                    idx <= head;
                    ii  <= head[IW-1:0];
                    if (func == rqss_pkg::FN_SERVE) begin
                      state <= S_SERVE;
                    end else if (func == rqss_pkg::FN_LIST) begin
                      state <= S_LIST;
                    end else begin
                      state <= S_SORTLD;
                    end
                  end
                end
                rqss_pkg::FN_SEARCH: begin
                  if (empty) begin
                    report     <= 1'b1;
                    rep_status <= rqss_pkg::ST_NOTFOUND;
                  end else begin
                    idx   <= head;
                    key   <= key_in;
                    state <= S_SEARCH;
                  end
                end
                default: begin
                  state <= S_IDLE;
                end
              endcase
            end
          end
          S_PLACE: begin
            if (hit && out_free) begin
              out_rec    <= hold;
              out_status <= rqss_pkg::ST_OK;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
          end
          S_SERVE: begin
            if (hit && out_free) begin
              out_rec    <= cell0;
              out_status <= rqss_pkg::ST_OK;
              out_last   <= 1'b1;
              head       <= head + 1'b1;
              state      <= S_IDLE;
            end
          end
          S_LIST: begin
            if (hit && out_free) begin
              out_rec    <= cell0;
              out_status <= rqss_pkg::ST_OK;
              out_last   <= (idx == {1'b0, tail});
              idx        <= idx + 1'b1;
              if (idx == {1'b0, tail}) begin
                state <= S_IDLE;
              end
            end
          end
          S_SEARCH: begin
            if (hit) begin
              if (cell0.id == key) begin
                if (out_free) begin
                  out_rec    <= cell0;
                  out_status <= rqss_pkg::ST_OK;
                  out_last   <= 1'b1;
                  state      <= S_IDLE;
                end
              end else if (idx == {1'b0, tail}) begin
                report     <= 1'b1;
                rep_status <= rqss_pkg::ST_NOTFOUND;
                state      <= S_IDLE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
          end
          S_SORTLD: begin
            // Wait for slot i to come round, then hold it as the running minimum.
            if (hit) begin
              hold  <= cell0;
              idx   <= idx + 1'b1;
              state <= S_SORTSC;
            end
          end
          S_SORTSC: begin
            if (idx > {1'b0, tail}) begin
              idx   <= {1'b0, ii};
              state <= S_SORTST;
            end else begin
              if (hold.price > cell0.price) begin
                hold <= cell0;
              end
              idx <= idx + 1'b1;
            end
          end
          S_SORTST: begin
            if (hit) begin
              if (ii == tail) begin
                report     <= 1'b1;
                rep_status <= rqss_pkg::ST_OK;
                state      <= S_IDLE;
              end else begin
                ii    <= ii + 1'b1;
                idx   <= {1'b0, ii} + 1'b1;
                state <= S_SORTLD;
              end
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // The sort scan relies on the ring standing on the slot being compared.
  `RQSS_ASSERT_NOW(a_sort_aligned, (state == S_SORTSC) && (idx <= {1'b0, tail}), hit, "sort scan off slot")
  `RQSS_ASSERT_NOW(a_head_bound, started, head <= {1'b0, tail} + 1'b1, "head beyond tail")
  `RQSS_ASSERT_NOW(a_head_idle, !started, head == '0, "head moved before place")
  `RQSS_ASSERT_NEXT(a_place_start, accept && func == rqss_pkg::FN_PLACE, started,
                    "place did not start queue")

endmodule
